FILE: hdl/cfrq_pkg.sv
// ----------------------------------------------------------------------------
// cfrq_pkg
// Shared types and constants of the checked frame receive queue: item codes,
// status codes, the command passed from the checker to the frame store and
// the result item.
// ----------------------------------------------------------------------------
package cfrq_pkg;

    // Kind of input item
    typedef enum logic [1:0] {
        FUNC_DATA    = 2'd0,
        FUNC_READ    = 2'd1,
        FUNC_RELEASE = 2'd2,
        FUNC_NONE    = 2'd3
    } t_func;

    // Status reported with every result item
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_HEADER = 3'd1,
        ST_CHECK_FAIL = 3'd2,
        ST_LEN_BAD    = 3'd3,
        ST_NO_ROOM    = 3'd4
    } t_status;

    // Command kinds queued between checker and frame store
    typedef enum logic [1:0] {
        CMD_DATA    = 2'd0,
        CMD_END     = 2'd1,
        CMD_READ    = 2'd2,
        CMD_RELEASE = 2'd3
    } t_cmd_kind;

    // Frame store state machine
    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_EXEC = 1'b1
    } t_back_state;

    // Frame layout
    localparam logic [7:0] HDR_RESET   = 8'hDF;
    localparam int         LEN_HI_POS  = 3;
    localparam int         LEN_LO_POS  = 4;
    localparam int         MIN_FRAME   = 5;
    localparam int         LEN_BIAS    = 6;
    localparam int         DLEN_W      = 17;

    // Queue depths
    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    // Command from checker to frame store (position and length travel beside it)
    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  data;
        logic        first;     // first byte of a datagram
        logic        wr_en;     // byte inside the frame window / offset in range
        t_status     status;    // checker verdict on an end item
        logic [9:0]  flen;      // reported frame length on an end item
    } t_cmd;

    // Result item
    typedef struct packed {
        t_status     status;
        logic [7:0]  frame_byte;
        logic [9:0]  frame_length;
        logic        queue_empty;
        logic [3:0]  frames_held;
    } t_result;

endpackage

FILE: hdl/checked_frame_receive_queue_top.sv
// ----------------------------------------------------------------------------
// checked_frame_receive_queue_top
// Checked frame receive queue: checks frames in datagram bytes and keeps good
// frames in a ring of slots for byte reads and release.
// ----------------------------------------------------------------------------
// Per datagram byte taken, the checker updates header match, length and XOR
// on the spot and queues a command, and the frame store writes the byte as it
// takes that command, so bytes stream at one per cycle while full is low. A
// read or a release of the oldest frame uses the idle and the execute state
// of the frame store, for the registered read ports of the frame and slot
// length memories. Four commands may wait between checker and store, and two
// results may wait on the output; full rises only when the command queue is
// full. The store takes a command only while the result queue has room, so a
// stalled result side backs up into the command queue and raises full. Each
// datagram end, read and release gives one result; other items give none.
// ----------------------------------------------------------------------------
module checked_frame_receive_queue_top #(
    parameter int FRAME_SLOTS = 8,
    parameter int MAX_FRAME   = 512
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data,
    // input items
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_func,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic [8:0] i_read_offset,
    // result items
    output logic       empty,
    input  logic       pop,
    output logic [2:0] o_status,
    output logic [7:0] o_frame_byte,
    output logic [9:0] o_frame_length,
    output logic       o_queue_empty,
    output logic [3:0] o_frames_held
);

    localparam int POS_W = $clog2(MAX_FRAME + 1);
    localparam int CMD_W = $bits(cfrq_pkg::t_cmd) + 2 * POS_W;
    localparam int RES_W = $bits(cfrq_pkg::t_result);

    cfrq_pkg::t_cmd    fr_cmd, bk_cmd;
    logic [POS_W-1:0]  fr_pos, fr_len, bk_pos, bk_len;
    logic [CMD_W-1:0]  cmd_rdata;
    logic              cmd_push, cmd_full, cmd_pop, cmd_empty;

    cfrq_pkg::t_result bk_res, res_out;
    logic [RES_W-1:0]  res_rdata;
    logic              res_push, res_full;

    assign o_cfg_ready = 1'b1;

    // checker
    cfrq_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_push        (push),
        .i_func        (i_func),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .i_read_offset (i_read_offset),
        .i_cmd_full    (cmd_full),
        .o_cmd_push    (cmd_push),
        .o_cmd         (fr_cmd),
        .o_cmd_pos     (fr_pos),
        .o_cmd_len     (fr_len)
    );

    assign full = cmd_full;

    // command queue
    cfrq_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (cfrq_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  ({fr_cmd, fr_pos, fr_len}),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_rdata),
        .o_empty (cmd_empty)
    );

    assign {bk_cmd, bk_pos, bk_len} = cmd_rdata;

    // frame store
    cfrq_back #(
        .FRAME_SLOTS (FRAME_SLOTS),
        .MAX_FRAME   (MAX_FRAME)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (bk_cmd),
        .i_cmd_pos   (bk_pos),
        .i_cmd_len   (bk_len),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (bk_res)
    );

    // result queue
    cfrq_fifo #(
        .WIDTH (RES_W),
        .DEPTH (cfrq_pkg::RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (bk_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_rdata),
        .o_empty (empty)
    );

    assign res_out        = res_rdata;
    assign o_status       = res_out.status;
    assign o_frame_byte   = res_out.frame_byte;
    assign o_frame_length = res_out.frame_length;
    assign o_queue_empty  = res_out.queue_empty;
    assign o_frames_held  = res_out.frames_held;

endmodule

FILE: hdl/cfrq_fifo.sv
// ----------------------------------------------------------------------------
// cfrq_fifo
// Small register FIFO used for the command queue and the result queue.
// ----------------------------------------------------------------------------
module cfrq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and fill count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr + 1'b1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd + 1'b1);
        end
        if (do_push && !do_pop) begin
            n_cnt = CNT_W'(r_cnt + 1'b1);
        end else if (do_pop && !do_push) begin
            n_cnt = CNT_W'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: hdl/cfrq_front.sv
// ----------------------------------------------------------------------------
// cfrq_front
// Item intake and frame checker: tracks byte position, declared length, header match
// and XOR check, and turns items into store commands; ignored items and non-final bytes past the window give none.
// ----------------------------------------------------------------------------
module cfrq_front #(
    parameter int MAX_FRAME = 512
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_valid,
    input  logic [7:0]                            i_cfg_data,
    // input items
    input  logic                                  i_push,
    input  logic [1:0]                            i_func,
    input  logic [7:0]                            i_data_byte,
    input  logic                                  i_last_byte,
    input  logic [8:0]                            i_read_offset,
    // command queue
    input  logic                                  i_cmd_full,
    output logic                                  o_cmd_push,
    output cfrq_pkg::t_cmd                        o_cmd,
    output logic [$clog2(MAX_FRAME + 1)-1:0]      o_cmd_pos,
    output logic [$clog2(MAX_FRAME + 1)-1:0]      o_cmd_len
);

    localparam int POS_W  = $clog2(MAX_FRAME + 1);
    localparam int DLEN_W = cfrq_pkg::DLEN_W;

    logic [7:0]        r_header;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [DLEN_W-1:0] r_dlen, n_dlen;
    logic [7:0]        r_xor, n_xor;
    logic              r_hdr_ok, n_hdr_ok;

    cfrq_pkg::t_func   func;
    logic              take, in_win, first, xor_on, len_bad;
    logic [POS_W-1:0]  pos_upd;
    logic [DLEN_W-1:0] dl_upd;
    logic [7:0]        x_upd;
    logic              hs_upd;

    assign func  = cfrq_pkg::t_func'(i_func);
    assign take  = i_push && !i_cmd_full;
    assign in_win = (r_pos < POS_W'(MAX_FRAME));
    assign first = (r_pos == '0);

    // per-byte update of the checker state
    always_comb begin
        hs_upd = first ? (i_data_byte == r_header) : r_hdr_ok;
        if (r_pos == POS_W'(cfrq_pkg::LEN_HI_POS)) begin
            dl_upd = DLEN_W'({i_data_byte, 8'h00});
        end else if (r_pos == POS_W'(cfrq_pkg::LEN_LO_POS)) begin
            dl_upd = r_dlen + DLEN_W'(i_data_byte) + DLEN_W'(cfrq_pkg::LEN_BIAS);
        end else begin
            dl_upd = r_dlen;
        end
        xor_on = (r_pos != '0)
              && ((r_pos < POS_W'(cfrq_pkg::MIN_FRAME)) || (DLEN_W'(r_pos) < dl_upd));
        x_upd   = xor_on ? (r_xor ^ i_data_byte) : r_xor;
        pos_upd = POS_W'(r_pos + 1'b1);
        // bytes past the window leave everything as it was
        if (!in_win) begin
            hs_upd  = r_hdr_ok;
            dl_upd  = r_dlen;
            x_upd   = r_xor;
            pos_upd = r_pos;
        end
        len_bad = (pos_upd < POS_W'(cfrq_pkg::MIN_FRAME)) || (dl_upd > DLEN_W'(pos_upd));
    end

    // next state, command build
    always_comb begin
        n_pos    = r_pos;
        n_dlen   = r_dlen;
        n_xor    = r_xor;
        n_hdr_ok = r_hdr_ok;

        o_cmd_push   = 1'b0;
        o_cmd.kind   = cfrq_pkg::CMD_DATA;
        o_cmd.data   = i_data_byte;
        o_cmd.first  = first;
        o_cmd.wr_en  = in_win;
        o_cmd.status = cfrq_pkg::ST_OK;
        o_cmd.flen   = '0;
        o_cmd_pos    = r_pos;
        o_cmd_len    = POS_W'(dl_upd);

        unique case (func)
            cfrq_pkg::FUNC_DATA: begin
                if (i_last_byte) begin
                    o_cmd_push = take;
                    o_cmd.kind = cfrq_pkg::CMD_END;
                    o_cmd.flen = (pos_upd >= POS_W'(cfrq_pkg::MIN_FRAME)) ? 10'(dl_upd) : 10'd0;
                    if (!hs_upd) begin
                        o_cmd.status = cfrq_pkg::ST_BAD_HEADER;
                        o_cmd.flen   = '0;
                    end else if (len_bad) begin
                        o_cmd.status = cfrq_pkg::ST_LEN_BAD;
                    end else if (x_upd != 8'h00) begin
                        o_cmd.status = cfrq_pkg::ST_CHECK_FAIL;
                    end
                    if (take) begin
                        n_pos    = '0;
                        n_dlen   = '0;
                        n_xor    = '0;
                        n_hdr_ok = 1'b0;
                    end
                end else begin
                    o_cmd_push = take && in_win;
                    if (take) begin
                        n_pos    = pos_upd;
                        n_dlen   = dl_upd;
                        n_xor    = x_upd;
                        n_hdr_ok = hs_upd;
                    end
                end
            end
            cfrq_pkg::FUNC_READ: begin
                o_cmd_push  = take;
                o_cmd.kind  = cfrq_pkg::CMD_READ;
                o_cmd.wr_en = (32'(i_read_offset) < 32'(MAX_FRAME));
                o_cmd_pos   = POS_W'(i_read_offset);
            end
            cfrq_pkg::FUNC_RELEASE: begin
                o_cmd_push = take;
                o_cmd.kind = cfrq_pkg::CMD_RELEASE;
            end
            cfrq_pkg::FUNC_NONE: begin
                o_cmd_push = 1'b0;
            end
        endcase
    end

    // checker state and header register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= cfrq_pkg::HDR_RESET;
            r_pos    <= '0;
            r_dlen   <= '0;
            r_xor    <= '0;
            r_hdr_ok <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_header <= i_cfg_data;
            end
            r_pos    <= n_pos;
            r_dlen   <= n_dlen;
            r_xor    <= n_xor;
            r_hdr_ok <= n_hdr_ok;
        end
    end

endmodule

FILE: hdl/cfrq_back.sv
// ----------------------------------------------------------------------------
// cfrq_back
// Frame store: ring of frame slots with write/read pointers, capture of
// checked frames, byte reads and release of the oldest frame.
// ----------------------------------------------------------------------------
module cfrq_back #(
    parameter int FRAME_SLOTS = 8,
    parameter int MAX_FRAME   = 512
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // command queue
    input  logic                                  i_cmd_valid,
    input  cfrq_pkg::t_cmd                        i_cmd,
    input  logic [$clog2(MAX_FRAME + 1)-1:0]      i_cmd_pos,
    input  logic [$clog2(MAX_FRAME + 1)-1:0]      i_cmd_len,
    output logic                                  o_cmd_pop,
    // result queue
    input  logic                                  i_res_full,
    output logic                                  o_res_push,
    output cfrq_pkg::t_result                     o_res
);

    localparam int POS_W  = $clog2(MAX_FRAME + 1);
    localparam int OFF_W  = $clog2(MAX_FRAME);
    localparam int SLOT_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam int CNT_W  = $clog2(FRAME_SLOTS + 1);

    // frame store and slot lengths
    logic [7:0]       r_store   [FRAME_SLOTS][MAX_FRAME];
    logic [POS_W-1:0] r_len_mem [FRAME_SLOTS];

    cfrq_pkg::t_back_state r_state, n_state;
    logic [SLOT_W-1:0] r_ws, n_ws, r_rs, n_rs;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_capture, n_capture;

    // registered read side
    logic [7:0]          r_rdata;
    logic [POS_W-1:0]    r_len_q;
    logic [POS_W-1:0]    r_off;
    logic                r_hit;
    cfrq_pkg::t_cmd_kind r_kind;

    logic q_full, q_empty, capture_now, store_we, len_we, rd_en;

    assign q_full      = (r_count == CNT_W'(FRAME_SLOTS));
    assign q_empty     = (r_count == '0);
    assign capture_now = i_cmd.first ? !q_full : r_capture;

    // command execution
    always_comb begin
        n_state   = r_state;
        n_ws      = r_ws;
        n_rs      = r_rs;
        n_count   = r_count;
        n_capture = r_capture;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        store_we   = 1'b0;
        len_we     = 1'b0;
        rd_en      = 1'b0;

        unique case (r_state)
            cfrq_pkg::BK_IDLE: begin
                if (i_cmd_valid && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.kind)
                        cfrq_pkg::CMD_DATA: begin
                            n_capture = capture_now;
                            store_we  = capture_now && !q_full && i_cmd.wr_en;
                        end
                        cfrq_pkg::CMD_END: begin
                            n_capture          = 1'b0;
                            store_we           = capture_now && !q_full && i_cmd.wr_en;
                            o_res_push         = 1'b1;
                            o_res.status       = i_cmd.status;
                            o_res.frame_length = i_cmd.flen;
                            if (i_cmd.status == cfrq_pkg::ST_OK) begin
                                if (capture_now && !q_full) begin
                                    len_we  = 1'b1;
                                    n_ws    = (r_ws == SLOT_W'(FRAME_SLOTS - 1))
                                              ? '0 : SLOT_W'(r_ws + 1'b1);
                                    n_count = CNT_W'(r_count + 1'b1);
                                end else begin
                                    o_res.status = cfrq_pkg::ST_NO_ROOM;
                                end
                            end
                        end
                        cfrq_pkg::CMD_READ, cfrq_pkg::CMD_RELEASE: begin
                            if (q_empty) begin
                                o_res_push   = 1'b1;
                                o_res.status = cfrq_pkg::ST_NO_ROOM;
                            end else begin
                                rd_en   = 1'b1;
                                n_state = cfrq_pkg::BK_EXEC;
                            end
                        end
                    endcase
                end
            end
            cfrq_pkg::BK_EXEC: begin
                o_res_push         = 1'b1;
                o_res.status       = cfrq_pkg::ST_OK;
                o_res.frame_length = 10'(r_len_q);
                if (r_kind == cfrq_pkg::CMD_READ) begin
                    o_res.frame_byte = (r_hit && (r_off < r_len_q)) ? r_rdata : 8'h00;
                end else begin
                    n_rs    = (r_rs == SLOT_W'(FRAME_SLOTS - 1)) ? '0 : SLOT_W'(r_rs + 1'b1);
                    n_count = CNT_W'(r_count - 1'b1);
                end
                n_state = cfrq_pkg::BK_IDLE;
            end
        endcase

        // occupancy as it stands after this item
        o_res.queue_empty = (n_count == '0);
        o_res.frames_held = 4'(n_count);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cfrq_pkg::BK_IDLE;
            r_ws      <= '0;
            r_rs      <= '0;
            r_count   <= '0;
            r_capture <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ws      <= n_ws;
            r_rs      <= n_rs;
            r_count   <= n_count;
            r_capture <= n_capture;
        end
    end

    // frame store port
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_ws][i_cmd_pos[OFF_W-1:0]] <= i_cmd.data;
        end
        if (rd_en) begin
            r_rdata <= r_store[r_rs][i_cmd_pos[OFF_W-1:0]];
        end
    end

    // slot length memory port
    always_ff @(posedge i_clk) begin
        if (len_we) begin
            r_len_mem[r_ws] <= i_cmd_len;
        end
        if (rd_en) begin
            r_len_q <= r_len_mem[r_rs];
        end
    end

    // held command fields for the execute state
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_kind <= i_cmd.kind;
            r_off  <= i_cmd_pos;
            r_hit  <= i_cmd.wr_en;
        end
    end

    // equal pointers mean an empty or a full ring
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ws == r_rs) |-> (r_count == '0 || r_count == CNT_W'(FRAME_SLOTS)))
        else $error("ring pointers disagree with frame count");

    // the execute state of a read or release is always followed by idle
    a_exec_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cfrq_pkg::BK_EXEC) |=> (r_state == cfrq_pkg::BK_IDLE))
        else $error("frame store stayed in execute");

    // a result is never pushed into a full result queue
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into full queue");

    // a frame is committed only when a slot is free
    a_commit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        len_we |-> (r_count != CNT_W'(FRAME_SLOTS)))
        else $error("frame committed into full ring");

endmodule

FILE: tb/sv/frame_queue_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_queue_monitor
// Watches the input, result and configuration channels of the checked frame
// receive queue. It keeps its own model of the receive checker and the frame
// ring, predicts the result item of each accepted input item that gives one and
// compares every popped result with the oldest prediction.
// ----------------------------------------------------------------------------
module frame_queue_monitor #(
    parameter int FRAME_SLOTS = 8,
    parameter int MAX_FRAME   = 512
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [7:0] i_cfg_data,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [1:0] i_func,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic [8:0] i_read_offset,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic [2:0] i_status,
    input  logic [7:0] i_frame_byte,
    input  logic [9:0] i_frame_length,
    input  logic       i_queue_empty,
    input  logic [3:0] i_frames_held,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);

    // Header register and receive state
    logic [7:0]  header_reg;
    logic [9:0]  rx_pos;
    logic [16:0] rx_decl;
    logic [7:0]  rx_xor;
    logic        rx_hdr_ok;
    logic        rx_capture;

    // Frame ring
    logic [7:0]  store_mem [FRAME_SLOTS * MAX_FRAME];
    logic [9:0]  slot_len [FRAME_SLOTS];
    int unsigned wr_slot;
    int unsigned rd_slot;
    logic        ring_full;

    cfrq_pkg::t_result awaited_results[$];
    cfrq_pkg::t_result want;

    function automatic logic ring_is_empty();
        return !ring_full && (rd_slot == wr_slot);
    endfunction

    // Result item as seen after the state update
    function automatic cfrq_pkg::t_result pack_result(cfrq_pkg::t_status st,
                                                      logic [7:0] fb, logic [9:0] fl);
        cfrq_pkg::t_result r;
        r.status       = st;
        r.frame_byte   = fb;
        r.frame_length = fl;
        r.queue_empty  = ring_is_empty();
        r.frames_held  = ring_full ? 4'(FRAME_SLOTS)
                                   : 4'((wr_slot + FRAME_SLOTS - rd_slot) % FRAME_SLOTS);
        return r;
    endfunction

    function automatic void clear_receive();
        rx_pos     = '0;
        rx_decl    = '0;
        rx_xor     = '0;
        rx_hdr_ok  = 1'b0;
        rx_capture = 1'b0;
    endfunction

    // Apply one accepted input item and queue the result it causes, if any
    function automatic void advance_frame_queue(cfrq_pkg::t_func f, logic [7:0] b,
                                                logic last, logic [8:0] off);
        cfrq_pkg::t_status st;
        logic [9:0] fl;
        logic [9:0] len;
        logic [7:0] fb;
        if (f == cfrq_pkg::FUNC_DATA) begin
            // bytes past the frame window are dropped, position saturates
            if (rx_pos < MAX_FRAME) begin
                if (rx_pos == 0) begin
                    rx_hdr_ok  = (b == header_reg);
                    rx_capture = !ring_full;
                end
                if (rx_capture && !ring_full)
                    store_mem[wr_slot * MAX_FRAME + rx_pos] = b;
                if (rx_pos == cfrq_pkg::LEN_HI_POS)
                    rx_decl = 17'({b, 8'h00});
                else if (rx_pos == cfrq_pkg::LEN_LO_POS)
                    rx_decl = 17'(rx_decl + b + cfrq_pkg::LEN_BIAS);
                if (rx_pos >= 1 && (rx_pos < cfrq_pkg::MIN_FRAME || rx_pos < rx_decl))
                    rx_xor ^= b;
                rx_pos = rx_pos + 10'd1;
            end
            if (!last)
                return;
            // datagram end: header, length, check, room
            fl = (rx_pos >= cfrq_pkg::MIN_FRAME) ? rx_decl[9:0] : 10'd0;
            if (!rx_hdr_ok) begin
                st = cfrq_pkg::ST_BAD_HEADER;
                fl = 10'd0;
            end else if (rx_pos < cfrq_pkg::MIN_FRAME || rx_decl > rx_pos) begin
                st = cfrq_pkg::ST_LEN_BAD;
            end else if (rx_xor != 8'd0) begin
                st = cfrq_pkg::ST_CHECK_FAIL;
            end else if (!rx_capture || ring_full) begin
                st = cfrq_pkg::ST_NO_ROOM;
            end else begin
                st = cfrq_pkg::ST_OK;
                slot_len[wr_slot] = rx_decl[9:0];
                wr_slot = (wr_slot + 1) % FRAME_SLOTS;
                if (wr_slot == rd_slot)
                    ring_full = 1'b1;
            end
            clear_receive();
            awaited_results.push_back(pack_result(st, 8'd0, fl));
            return;
        end
        if (f == cfrq_pkg::FUNC_NONE)
            return;
        if (ring_is_empty()) begin
            awaited_results.push_back(pack_result(cfrq_pkg::ST_NO_ROOM, 8'd0, 10'd0));
            return;
        end
        len = slot_len[rd_slot];
        if (f == cfrq_pkg::FUNC_READ) begin
            fb = 8'd0;
            if (off < len && off < MAX_FRAME)
                fb = store_mem[rd_slot * MAX_FRAME + off];
            awaited_results.push_back(pack_result(cfrq_pkg::ST_OK, fb, len));
        end else begin
            // release wipes the oldest slot
            for (int i = 0; i < MAX_FRAME; i++)
                store_mem[rd_slot * MAX_FRAME + i] = 8'd0;
            rd_slot = (rd_slot + 1) % FRAME_SLOTS;
            ring_full = 1'b0;
            awaited_results.push_back(pack_result(cfrq_pkg::ST_OK, 8'd0, len));
        end
    endfunction

    task automatic compare_field(string name, int unsigned exp_val, int unsigned act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    // Track the channels at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            header_reg = cfrq_pkg::HDR_RESET;
            clear_receive();
            for (int i = 0; i < FRAME_SLOTS * MAX_FRAME; i++)
                store_mem[i] = 8'd0;
            for (int i = 0; i < FRAME_SLOTS; i++)
                slot_len[i] = 10'd0;
            wr_slot   = 0;
            rd_slot   = 0;
            ring_full = 1'b0;
            awaited_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                header_reg = i_cfg_data;
            if (i_push && !i_full)
                advance_frame_queue(cfrq_pkg::t_func'(i_func), i_data_byte, i_last_byte,
                                    i_read_offset);
            if (i_pop && !i_empty) begin
                if (awaited_results.size() == 0) begin
                    $error("result item popped with none awaited");
                    o_fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("status", want.status, i_status);
                    compare_field("frame_byte", want.frame_byte, i_frame_byte);
                    compare_field("frame_length", want.frame_length, i_frame_length);
                    compare_field("queue_empty", want.queue_empty, i_queue_empty);
                    compare_field("frames_held", want.frames_held, i_frames_held);
                    o_checked++;
                end
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

FILE: tb/sv/tb_checked_frame_receive_queue_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_checked_frame_receive_queue_top
// Stimulus and verdict for the checked frame receive queue: a directed opening,
// then phases of random datagrams, reads and releases under several header
// settings, with random idling on both sides; the monitor does the checking.
// ----------------------------------------------------------------------------
module tb_checked_frame_receive_queue_top;

    localparam int FRAME_SLOTS = 8;
    localparam int MAX_FRAME   = 512;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE      = 20;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data = 8'd0;
    logic       push = 1'b0;
    logic       full;
    logic [1:0] i_func = cfrq_pkg::FUNC_DATA;
    logic [7:0] i_data_byte = 8'd0;
    logic       i_last_byte = 1'b0;
    logic [8:0] i_read_offset = 9'd0;
    logic       empty;
    logic       pop = 1'b0;
    logic [2:0] o_status;
    logic [7:0] o_frame_byte;
    logic [9:0] o_frame_length;
    logic       o_queue_empty;
    logic [3:0] o_frames_held;

    int         fail_count;
    int         pending;
    int         checked;
    int         cycle_count = 0;
    int         sent_count = 0;
    logic       steady = 1'b0;
    logic [7:0] cur_header = cfrq_pkg::HDR_RESET;
    logic [7:0] dgram[$];

    checked_frame_receive_queue_top #(
        .FRAME_SLOTS (FRAME_SLOTS),
        .MAX_FRAME   (MAX_FRAME)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_func         (i_func),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_read_offset  (i_read_offset),
        .empty          (empty),
        .pop            (pop),
        .o_status       (o_status),
        .o_frame_byte   (o_frame_byte),
        .o_frame_length (o_frame_length),
        .o_queue_empty  (o_queue_empty),
        .o_frames_held  (o_frames_held)
    );

    frame_queue_monitor #(
        .FRAME_SLOTS (FRAME_SLOTS),
        .MAX_FRAME   (MAX_FRAME)
    ) monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_push         (push),
        .i_full         (full),
        .i_func         (i_func),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_read_offset  (i_read_offset),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_status       (o_status),
        .i_frame_byte   (o_frame_byte),
        .i_frame_length (o_frame_length),
        .i_queue_empty  (o_queue_empty),
        .i_frames_held  (o_frames_held),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    // 12 ns clock
    always #6 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: random stalls except in the steady stretch
    always @(negedge i_clk) begin
        pop = steady || ($urandom_range(0, 99) >= 34);
    end

    // One input item, with an optional random gap in front
    task automatic send_item(cfrq_pkg::t_func f, logic [7:0] b, logic l, logic [8:0] off);
        while (!steady && $urandom_range(0, 99) < 34) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push          = 1'b1;
        i_func        = f;
        i_data_byte   = b;
        i_last_byte   = l;
        i_read_offset = off;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        @(negedge i_clk);
        if (f != cfrq_pkg::FUNC_NONE)
            sent_count++;
    endtask

    // Read, release or an ignored item on the oldest frame
    task automatic send_queue_op(int release_pct);
        logic [8:0] off;
        off = ($urandom_range(0, 99) < 80) ? 9'($urandom_range(0, 31))
                                           : 9'($urandom_range(0, 511));
        if ($urandom_range(0, 99) < 5)
            send_item(cfrq_pkg::FUNC_NONE, 8'($urandom), 1'($urandom), 9'($urandom));
        else if ($urandom_range(0, 99) < release_pct)
            send_item(cfrq_pkg::FUNC_RELEASE, 8'($urandom), 1'($urandom), off);
        else
            send_item(cfrq_pkg::FUNC_READ, 8'($urandom), 1'($urandom), off);
    endtask

    // Well-formed frame in dgram: header, two free bytes, count, payload, check byte, trail
    task automatic build_frame(logic [7:0] hdr, logic [15:0] count, int trail);
        logic [7:0] acc;
        logic [7:0] v;
        int         len;
        len = count + cfrq_pkg::LEN_BIAS;
        dgram.delete();
        dgram.push_back(hdr);
        dgram.push_back(8'($urandom));
        dgram.push_back(8'($urandom));
        dgram.push_back(count[15:8]);
        dgram.push_back(count[7:0]);
        acc = dgram[1] ^ dgram[2] ^ dgram[3] ^ dgram[4];
        for (int i = 5; i < len - 1; i++) begin
            v = 8'($urandom);
            dgram.push_back(v);
            acc ^= v;
        end
        dgram.push_back(acc);
        repeat (trail)
            dgram.push_back(8'($urandom));
    endtask

    // Send dgram, now and then slipping a queue op between its bytes
    task automatic send_datagram(int mix_pct, int release_pct);
        for (int i = 0; i < dgram.size(); i++) begin
            if ($urandom_range(0, 99) < mix_pct)
                send_queue_op(release_pct);
            send_item(cfrq_pkg::FUNC_DATA, dgram[i], i == dgram.size() - 1, 9'($urandom));
        end
    endtask

    // Header register write while the block is idle
    task automatic write_header(logic [7:0] v);
        push = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (16)
            @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        cur_header  = v;
    endtask

    // Random datagrams, mostly good, some broken, some noise
    task automatic run_phase(int n_items, int release_pct);
        int start;
        int pick;
        int idx;
        start = sent_count;
        while (sent_count - start < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                build_frame(cur_header,
                            ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 12))
                                                         : 16'($urandom_range(13, 40)),
                            ($urandom_range(0, 99) < 75) ? 0 : $urandom_range(1, 3));
                if (pick >= 70) begin
                    case ($urandom_range(0, 3))
                        0: begin
                            dgram[0] ^= 8'($urandom_range(1, 255));
                        end
                        1: begin
                            idx = $urandom_range(1, dgram[4] + cfrq_pkg::LEN_BIAS - 1);
                            dgram[idx] ^= 8'($urandom_range(1, 255));
                        end
                        2: begin
                            // cut short, to a random length below the datagram size
                            idx = $urandom_range(1, dgram.size() - 1);
                            while (dgram.size() > idx)
                                void'(dgram.pop_back());
                        end
                        default: begin
                            dgram[3] = 8'($urandom_range(1, 255));
                        end
                    endcase
                end
            end else begin
                dgram.delete();
                repeat ($urandom_range(1, 8))
                    dgram.push_back(8'($urandom));
                if ($urandom_range(0, 1))
                    dgram[0] = cur_header;
            end
            send_datagram(4, release_pct);
            repeat ($urandom_range(0, 2))
                send_queue_op(release_pct);
        end
    endtask

    initial begin
        repeat (10)
            @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: empty queue, minimal good frame, reads, release, each checker reject
        send_item(cfrq_pkg::FUNC_READ, 8'h00, 1'b0, 9'd0);
        send_item(cfrq_pkg::FUNC_RELEASE, 8'hFF, 1'b1, 9'h1FF);
        dgram = '{cfrq_pkg::HDR_RESET, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF};
        send_datagram(0, 0);
        send_item(cfrq_pkg::FUNC_READ, 8'hFF, 1'b1, 9'd0);
        send_item(cfrq_pkg::FUNC_READ, 8'h00, 1'b0, 9'h1FF);
        send_item(cfrq_pkg::FUNC_NONE, 8'hFF, 1'b1, 9'h1FF);
        send_item(cfrq_pkg::FUNC_RELEASE, 8'h00, 1'b0, 9'd0);
        dgram = '{cfrq_pkg::HDR_RESET, 8'h12};
        send_datagram(0, 0);
        dgram = '{8'h20};
        send_datagram(0, 0);
        dgram = '{cfrq_pkg::HDR_RESET, 8'h00, 8'h00, 8'h01, 8'h00};
        send_datagram(0, 0);
        dgram = '{cfrq_pkg::HDR_RESET, 8'h01, 8'h02, 8'h00, 8'h00, 8'h00};
        send_datagram(0, 0);

        // Fill: few releases, so the ring runs full
        run_phase(40, 10);
        repeat (FRAME_SLOTS) begin
            build_frame(cur_header, 16'd0, 0);
            send_datagram(0, 0);
        end
        // datagram begun on a full ring stays dropped across a release
        build_frame(cur_header, 16'd0, 0);
        for (int i = 0; i < dgram.size(); i++) begin
            if (i == 1)
                send_item(cfrq_pkg::FUNC_RELEASE, 8'($urandom), 1'($urandom), 9'($urandom));
            send_item(cfrq_pkg::FUNC_DATA, dgram[i], i == dgram.size() - 1, 9'($urandom));
        end

        // Header 0x00, no idling on either side
        write_header(8'h00);
        steady <= 1'b1;
        run_phase(40, 50);
        steady <= 1'b0;

        // Header 0xFF, mostly releases so the ring drains
        write_header(8'hFF);
        run_phase(40, 80);

        write_header(8'($urandom));
        run_phase(30, 40);

        // Full-size frame with a tail past the frame window
        write_header(cfrq_pkg::HDR_RESET);
        repeat (FRAME_SLOTS)
            send_item(cfrq_pkg::FUNC_RELEASE, 8'($urandom), 1'($urandom), 9'($urandom));
        build_frame(cur_header, 16'(MAX_FRAME - cfrq_pkg::LEN_BIAS), 4);
        send_datagram(0, 0);
        send_item(cfrq_pkg::FUNC_READ, 8'($urandom), 1'($urandom), 9'd0);
        send_item(cfrq_pkg::FUNC_READ, 8'($urandom), 1'($urandom), 9'h1FF);
        send_item(cfrq_pkg::FUNC_READ, 8'($urandom), 1'($urandom), 9'($urandom));
        send_item(cfrq_pkg::FUNC_RELEASE, 8'($urandom), 1'($urandom), 9'($urandom));

        // Drain and settle
        push = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (SETTLE)
            @(negedge i_clk);

        $display("Sent %0d items, compared %0d result items", sent_count, checked);
        $display("Headers 0xDF, 0x00, 0xFF and one random; full ring, empty ring, 512-byte frame");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
